>>> design/voxel_occupancy_point_filter_assert.svh
// assertion macros for the voxel occupancy point filter
`ifndef VOXEL_OCCUPANCY_POINT_FILTER_ASSERT_SVH
`define VOXEL_OCCUPANCY_POINT_FILTER_ASSERT_SVH
// property that must hold on every clock edge outside reset
`define VOP_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// implication checked on the following clock edge
`define VOP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/vop_pkg.sv
// shared types and constants for the voxel occupancy point filter
`timescale 1ns / 1ps
package vop_pkg;
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [15:0] LEAF_RESET = 16'd200;

   typedef struct packed {
      logic [1:0]         kind;
      logic               point_valid;
      logic signed [15:0] x_mm;
      logic signed [15:0] y_mm;
      logic signed [15:0] z_mm;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x_mm;
      logic signed [15:0] out_y_mm;
      logic signed [15:0] out_z_mm;
      logic               table_overflowed;
   } rsp_type;

   // work item handed from front to back
   typedef struct packed {
      logic               is_clear;
      logic               is_insert;
      logic [47:0]        key;
      logic signed [15:0] x_mm;
      logic signed [15:0] y_mm;
      logic signed [15:0] z_mm;
   } work_type;
endpackage

>>> design/voxel_occupancy_point_filter.sv
// top level of the voxel occupancy point filter
// results: only a query whose key is not in the table gives one; inserts and table hits give none
// division yields 16 quotient bits per axis; the front takes no new point until the last is handed to the queue
// clear: front hands it to the queue without division, back end sweeps TABLE_DEPTH entries; long work stalls via queue
// reset: synchronous; the back end then sweeps TABLE_DEPTH entries before probing
// results appear for one cycle on rsp_strobe; the receiver cannot stall
`timescale 1ns / 1ps
`include "voxel_occupancy_point_filter_assert.svh"
module voxel_occupancy_point_filter #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vop_pkg::req_type req_item,
   input  logic             csr_we,
   input  logic [15:0]      csr_leaf_size_mm,
   output logic             rsp_strobe,
   output vop_pkg::rsp_type rsp_item
);
   // leaf size register
   logic [15:0] leaf_ff, leaf_in;

   // front to queue
   logic              f_valid, f_ready;
   vop_pkg::work_type f_data;
   // queue to back
   logic              b_valid, b_ready;
   vop_pkg::work_type b_data;
   logic              back_idle;
   // accepted transfer that needs division or a clear
   logic              work_taken;

   assign leaf_in = csr_we ? csr_leaf_size_mm : leaf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_ff <= vop_pkg::LEAF_RESET;
      end else begin
         leaf_ff <= leaf_in;
      end
   end

   // front: item filter and key divider
   vop_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req      (req_item),
      .leaf     (leaf_ff),
      .wk_valid (f_valid),
      .wk       (f_data),
      .wk_ready (f_ready)
   );

   // short queue decoupling division from probing
   vop_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .in_ready  (f_ready),
      .out_valid (b_valid),
      .out_data  (b_data),
      .out_ready (b_ready)
   );

   // back: hash table probing, clear sweep, results
   vop_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wk_valid   (b_valid),
      .wk         (b_data),
      .wk_ready   (b_ready),
      .idle       (back_idle),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

   assign work_taken = start && !busy
                       && (req_item.kind == vop_pkg::KIND_CLEAR
                           || ((req_item.kind == vop_pkg::KIND_INSERT
                                || req_item.kind == vop_pkg::KIND_QUERY)
                               && req_item.point_valid));

   // a clear or a valid point keeps the front busy on the next cycle
   `VOP_ASSERT_NEXT(a_start_busy, clock, reset, work_taken, busy, "front idle after work taken")
   // a result only leaves from an idle back end
   `VOP_ASSERT_ALWAYS(a_rsp_idle, clock, reset, !rsp_strobe || back_idle, "result while back busy")
   // a result strobe lasts exactly one cycle
   `VOP_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe held")
endmodule

>>> design/vop_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module vop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata <= mem_ff[addr];
   end
endmodule

>>> design/vop_front.sv
// front end: filters items and computes voxel keys with a serial divider
`timescale 1ns / 1ps
module vop_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vop_pkg::req_type req,
   input  logic [15:0]      leaf,
   output logic             wk_valid,
   output vop_pkg::work_type wk,
   input  logic             wk_ready
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  axis_ff, axis_in;
   logic [4:0]  bit_ff, bit_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [47:0] key_ff, key_in;
   vop_pkg::work_type item_ff, item_in;

   logic [15:0] div;
   logic [16:0] trial;
   logic        accept;
   logic [15:0] qfin;

   assign div    = (leaf == 16'd0) ? 16'd1 : leaf;
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wk_valid = (state_ff == ST_OUT);
   assign wk = item_ff;

   assign trial = {rem_ff[15:0], mag_ff[15]};

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      key_in   = key_ff;
      item_in  = item_ff;
      qfin     = 16'd0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in.is_clear  = (req.kind == vop_pkg::KIND_CLEAR);
               item_in.is_insert = (req.kind == vop_pkg::KIND_INSERT);
               item_in.key       = 48'd0;
               item_in.x_mm      = req.x_mm;
               item_in.y_mm      = req.y_mm;
               item_in.z_mm      = req.z_mm;
               if (req.kind == vop_pkg::KIND_CLEAR) begin
                  state_in = ST_OUT;
               end else if ((req.kind == vop_pkg::KIND_INSERT
                             || req.kind == vop_pkg::KIND_QUERY) && req.point_valid) begin
                  state_in = ST_DIV;
                  axis_in  = 2'd0;
                  bit_in   = 5'd0;
                  rem_in   = 17'd0;
                  quo_in   = 16'd0;
                  // magnitude of -1-v for negatives: floor(v/d) = -1 - (-1-v)/d
                  neg_in   = req.x_mm[15];
                  mag_in   = req.x_mm[15] ? ~req.x_mm : req.x_mm;
               end
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle
            if (trial >= {1'b0, div}) begin
               rem_in = trial - {1'b0, div};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            mag_in = {mag_ff[14:0], 1'b0};
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd15) begin
               qfin = neg_ff ? ~quo_in : quo_in;
               key_in = {key_ff[31:0], qfin};
               rem_in = 17'd0;
               quo_in = 16'd0;
               bit_in = 5'd0;
               if (axis_ff == 2'd2) begin
                  item_in.key = {key_ff[31:0], qfin};
                  state_in = ST_OUT;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  if (axis_ff == 2'd0) begin
                     neg_in = item_ff.y_mm[15];
                     mag_in = item_ff.y_mm[15] ? ~item_ff.y_mm : item_ff.y_mm;
                  end else begin
                     neg_in = item_ff.z_mm[15];
                     mag_in = item_ff.z_mm[15] ? ~item_ff.z_mm : item_ff.z_mm;
                  end
               end
            end
         end
         ST_OUT: begin
            if (wk_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      axis_ff <= axis_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      key_ff  <= key_in;
      item_ff <= item_in;
   end
endmodule

>>> design/vop_queue.sv
// two entry queue between front and back
`timescale 1ns / 1ps
module vop_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vop_pkg::work_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output vop_pkg::work_type out_data,
   input  logic              out_ready
);
   vop_pkg::work_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= in_data;
   end
endmodule

>>> design/vop_back.sv
// back end: linear probing over the key table, clear sweep and result output
`timescale 1ns / 1ps
module vop_back #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wk_valid,
   input  vop_pkg::work_type wk,
   output logic              wk_ready,
   output logic              idle,
   output logic              rsp_strobe,
   output vop_pkg::rsp_type  rsp
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] probe_ff, probe_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [31:0]   hash_ff, hash_in;
   vop_pkg::work_type cur_ff, cur_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   vop_pkg::rsp_type rsp_ff, rsp_in;
   logic [AW-1:0] fold;

   // each ram word: valid bit then key; valid cleared by a sweep
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [48:0]   ram_wdata, ram_rdata;

   vop_ram #(.WIDTH(49), .DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign wk_ready   = (state_ff == ST_IDLE);
   assign idle       = (state_ff == ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;
   assign fold       = hash_ff[AW-1:0] ^ AW'(hash_ff >> 11);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      probe_in = probe_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      hash_in  = hash_ff;
      cur_in   = cur_ff;
      rsp_strobe_in = 1'b0;
      rsp_in   = rsp_ff;
      ram_we   = 1'b0;
      ram_addr = slot_ff;
      ram_wdata = {1'b1, cur_ff.key};
      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = 49'd0;
            slot_in   = slot_ff + AW'(1);
            if (slot_ff == LAST) begin
               state_in = ST_IDLE;
               slot_in  = '0;
            end
         end
         ST_IDLE: begin
            if (wk_valid) begin
               cur_in = wk;
               if (wk.is_clear) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  slot_in  = '0;
                  state_in = ST_INIT;
               end else begin
                  // fold the key into a short hash, any spread will do
                  hash_in  = wk.key[47:16] ^ {wk.key[15:0], wk.key[47:32]}
                             ^ {wk.key[31:0] >> 7};
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            // bring the folded hash into the table range
            slot_in  = ({1'b0, fold} >= (AW+1)'(TABLE_DEPTH)) ? fold - AW'(TABLE_DEPTH) : fold;
            probe_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_addr = slot_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!ram_rdata[48]) begin
               if (cur_ff.is_insert) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{cur_ff.x_mm, cur_ff.y_mm, cur_ff.z_mm, ovf_ff};
               end
               state_in = ST_IDLE;
            end else if (ram_rdata[47:0] == cur_ff.key) begin
               state_in = ST_IDLE;
            end else if (probe_ff == CW'(TABLE_DEPTH - 1)) begin
               // whole table probed: key absent, no free slot
               if (cur_ff.is_insert) begin
                  ovf_in = 1'b1;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{cur_ff.x_mm, cur_ff.y_mm, cur_ff.z_mm, ovf_ff};
               end
               state_in = ST_IDLE;
            end else begin
               probe_in = probe_ff + CW'(1);
               slot_in  = (slot_ff == LAST) ? '0 : slot_ff + AW'(1);
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         slot_ff       <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      probe_ff <= probe_in;
      hash_ff  <= hash_in;
      cur_ff   <= cur_in;
      rsp_ff   <= rsp_in;
   end
endmodule
